@@ rtl/core/dic_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dic_pkg
// Shared constants for the dynamic inversion counter: command codes and the
// fixed widths of the item and result words.
// ----------------------------------------------------------------------------
package dic_pkg;

  localparam int CMD_W     = 2;
  localparam int IN_VAL_W  = 32;
  localparam int POS_W     = 11;
  localparam int INV_W     = 19;
  localparam int WIDE_W    = 64;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};

endpackage
`default_nettype wire

@@ rtl/core/dic_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dic_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module dic_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/core/dynamic_inversion_counter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dynamic_inversion_counter_unit
// Keeps a sequence of signed values with its inversion count; load appends,
// delete removes a position, clear restarts. Every word returns the count.
// ----------------------------------------------------------------------------
// One word is handled at a time. A load or a delete sweeps the single read port
// of the value memory once over all values loaded since the last clear, one
// entry per cycle; a delete first looks up the value at its position. Clear,
// unknown commands, rejected loads and deletes of a position outside the fill
// go straight to the result, and a delete of an already deleted position
// returns after the lookup, with no sweep. Each memory word
// holds a value and its live bit; entries at or above the fill count are
// treated as empty, so neither reset nor clear needs a pass over the memory.
// A new word is accepted while a finished result still waits on the output
// register.
module dynamic_inversion_counter_unit #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dic_pkg::CMD_W-1:0]   command_i,
  input  logic [dic_pkg::IN_VAL_W-1:0] item_value_i,
  input  logic [dic_pkg::POS_W-1:0]   position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dic_pkg::INV_W-1:0]   inversions_o,
  output logic                        error_o
);

  import dic_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int TOT_W  = 2 * IDX_W;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int SAT_W  = (TOT_W > INV_W) ? TOT_W : INV_W;
  localparam int WORD_W = VALUE_BITS + 1;
  localparam logic [VALUE_BITS-1:0] SIGN_FLIP = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [CNT_W-1:0]      FULL      = CNT_W'(MAX_ELEMENTS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOK   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_COMMIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] loaded_q, loaded_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic             deleting_q, deleting_d;
  logic             is_load_q, is_load_d;
  logic             err_q, err_d;
  logic [CNT_W-1:0] addr_q, addr_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] tgt_q, tgt_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic             out_valid_q, out_valid_d;
  logic [INV_W-1:0] inv_q, inv_d;
  logic             out_err_q, out_err_d;

  logic [WIDE_W-1:0]     val_wide;
  logic [VALUE_BITS-1:0] key_in;
  logic [CMP_W-1:0]      pos_ext, pos_m1;
  logic                  accept, clr_go, issue, hit;
  logic [IDX_W-1:0]      raddr, waddr;
  logic                  we;
  logic [WORD_W-1:0]     wdata, rdata;
  logic                  r_live;
  logic [VALUE_BITS-1:0] r_val;
  logic [SAT_W-1:0]      tot_wide;
  logic [INV_W-1:0]      tot_sat;

  assign val_wide = {{(WIDE_W-IN_VAL_W){item_value_i[IN_VAL_W-1]}}, item_value_i};
  assign key_in   = val_wide[VALUE_BITS-1:0] ^ SIGN_FLIP;
  assign pos_ext  = CMP_W'(position_i);
  assign pos_m1   = pos_ext - CMP_W'(1);
  assign accept   = in_valid_i && !in_stall_o;
  assign clr_go   = accept && (command_i == CMD_CLEAR);
  assign issue    = (state_q == S_SCAN) && (addr_q < loaded_q);
  assign r_live   = rdata[VALUE_BITS];
  assign r_val    = rdata[VALUE_BITS-1:0];
  assign tot_wide = SAT_W'(total_q);
  assign tot_sat  = (tot_wide > SAT_W'(INV_MAX)) ? INV_MAX : tot_wide[INV_W-1:0];

  always_comb begin
    if (is_load_q) begin
      hit = r_live && (r_val > key_q);
    end else begin
      hit = r_live && (((idx_q < tgt_q) && (r_val > key_q)) ||
                       ((idx_q > tgt_q) && (r_val < key_q)));
    end
  end

  always_comb begin
    if (state_q == S_SCAN) begin
      raddr = addr_q[IDX_W-1:0];
    end else begin
      raddr = pos_m1[IDX_W-1:0];
    end
    we    = (state_q == S_COMMIT);
    waddr = tgt_q[IDX_W-1:0];
    wdata = {is_load_q, key_q};
  end

  dic_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    total_d     = total_q;
    deleting_d  = deleting_q;
    is_load_d   = is_load_q;
    err_d       = err_q;
    addr_d      = addr_q;
    pend_d      = 1'b0;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    tgt_d       = tgt_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && out_stall_i;
    inv_d       = inv_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          addr_d = '0;
          cnt_d  = '0;
          err_d  = 1'b1;
          unique case (command_i)
            CMD_LOAD: begin
              is_load_d = 1'b1;
              key_d     = key_in;
              tgt_d     = loaded_q;
              if (deleting_q || (loaded_q == FULL)) begin
                state_d = S_DONE;
              end else begin
                err_d   = 1'b0;
                state_d = S_SCAN;
              end
            end
            CMD_DELETE: begin
              is_load_d = 1'b0;
              tgt_d     = CNT_W'(pos_m1);
              if ((pos_ext == '0) || (pos_ext > CMP_W'(loaded_q))) begin
                state_d = S_DONE;
              end else begin
                err_d   = 1'b0;
                state_d = S_LOOK;
              end
            end
            CMD_CLEAR: begin
              err_d      = 1'b0;
              loaded_d   = '0;
              total_d    = '0;
              deleting_d = 1'b0;
              state_d    = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_LOOK: begin
        key_d = r_val;
        if (r_live) begin
          state_d = S_SCAN;
        end else begin
          err_d   = 1'b1;
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        if (issue) begin
          pend_d = 1'b1;
          idx_d  = addr_q;
          addr_d = addr_q + CNT_W'(1);
        end
        if (pend_q) begin
          cnt_d = cnt_q + CNT_W'(hit);
        end
        if (!issue && !pend_q) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (is_load_q) begin
          loaded_d = loaded_q + CNT_W'(1);
          total_d  = total_q + TOT_W'(cnt_q);
        end else begin
          deleting_d = 1'b1;
          total_d    = (total_q >= TOT_W'(cnt_q)) ? (total_q - TOT_W'(cnt_q)) : '0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          inv_d       = tot_sat;
          out_err_d   = err_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loaded_q    <= '0;
      total_q     <= '0;
      deleting_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      total_q     <= total_d;
      deleting_q  <= deleting_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_load_q <= is_load_d;
    err_q     <= err_d;
    addr_q    <= addr_d;
    idx_q     <= idx_d;
    cnt_q     <= cnt_d;
    tgt_q     <= tgt_d;
    key_q     <= key_d;
    inv_q     <= inv_d;
    out_err_q <= out_err_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign inversions_o = inv_q;
  assign error_o      = out_err_q;

  // fill count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= FULL)
    else $error("fill count beyond depth");

  // scan never reads past the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (addr_q <= loaded_q))
    else $error("scan address beyond fill count");

  // a new result only comes from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && out_stall_i)) |-> (state_q == S_DONE))
    else $error("result loaded outside done state");

  // count drops only on a delete commit or a clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_d < total_q) |-> ((state_q == S_COMMIT && !is_load_q) || clr_go))
    else $error("count dropped without delete or clear");

  // a committed delete blocks further loads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && !is_load_q) |=> deleting_q)
    else $error("delete did not set deleting flag");

endmodule
`default_nettype wire

@@ tb/sv/dynamic_inversion_counter_unit_test.sv @@
// ----------------------------------------------------------------------------
// dynamic_inversion_counter_unit_test
// Drives load, delete, clear and unknown words into the inversion counter with
// random sender bursts and receiver stalls, tracks the live sequence and its
// inversion count alongside the block and checks every returned word in order.
// ----------------------------------------------------------------------------
module dynamic_inversion_counter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dic_pkg::*;

  localparam int SEQ_DEPTH = 1024;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [INV_W-1:0] inv;
    logic             err;
  } word_result_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i = CMD_CLEAR;
  logic [IN_VAL_W-1:0] item_value_i = '0;
  logic [POS_W-1:0]    position_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [INV_W-1:0]    inversions_o;
  logic                error_o;

  dynamic_inversion_counter_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .item_value_i (item_value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .inversions_o (inversions_o),
    .error_o      (error_o)
  );

  // live sequence as the block should hold it
  int signed    seq_value [SEQ_DEPTH];
  bit           seq_live [SEQ_DEPTH];
  int           seq_fill;
  longint       inv_total;
  bit           deletes_seen;

  word_result_t pending_results [$];
  int           mismatch_count;
  int           result_index;
  int           burst_left;
  int           stall_mode;
  int           stall_run;

  int           n_loads, n_deletes, n_clears, n_other, n_rejected;
  longint       peak_count;
  int           peak_fill;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at word %0d: %s got %0d want %0d", result_index, what, got, want);
  endtask

  task automatic update_inversion_count(input logic [CMD_W-1:0] cmd,
                                        input logic [IN_VAL_W-1:0] value,
                                        input logic [POS_W-1:0] pos);
    word_result_t r;
    int           k;
    int           idx;
    longint       delta;
    int signed    key;
    r.err = 1'b0;
    delta = 0;
    case (cmd)
      CMD_CLEAR: begin
        n_clears++;
        for (k = 0; k < SEQ_DEPTH; k++) seq_live[k] = 1'b0;
        seq_fill = 0;
        inv_total = 0;
        deletes_seen = 1'b0;
      end
      CMD_LOAD: begin
        n_loads++;
        if (deletes_seen || seq_fill >= SEQ_DEPTH) begin
          r.err = 1'b1;
        end else begin
          key = $signed(value);
          for (k = 0; k < seq_fill; k++)
            if (seq_live[k] && seq_value[k] > key) delta++;
          seq_value[seq_fill] = key;
          seq_live[seq_fill] = 1'b1;
          seq_fill++;
          inv_total += delta;
        end
      end
      CMD_DELETE: begin
        n_deletes++;
        if (pos == 0 || pos > seq_fill || !seq_live[pos - 1]) begin
          r.err = 1'b1;
        end else begin
          idx = pos - 1;
          key = seq_value[idx];
          for (k = 0; k < seq_fill; k++) begin
            if (seq_live[k] && k < idx && seq_value[k] > key) delta++;
            if (seq_live[k] && k > idx && seq_value[k] < key) delta++;
          end
          seq_live[idx] = 1'b0;
          deletes_seen = 1'b1;
          inv_total = (inv_total >= delta) ? inv_total - delta : 0;
        end
      end
      default: begin
        n_other++;
        r.err = 1'b1;
      end
    endcase
    r.inv = (inv_total > longint'(INV_MAX)) ? INV_MAX : inv_total[INV_W-1:0];
    if (r.err) n_rejected++;
    if (inv_total > peak_count) peak_count = inv_total;
    if (seq_fill > peak_fill) peak_fill = seq_fill;
    pending_results.push_back(r);
  endtask

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IN_VAL_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        command_i <= CMD_W'($urandom_range(0, 3));
        item_value_i <= $urandom;
        position_i <= POS_W'($urandom_range(0, 2047));
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    command_i <= cmd;
    item_value_i <= value;
    position_i <= pos;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    update_inversion_count(cmd, value, pos);
  endtask

  task automatic check_result();
    word_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("word with nothing pending, inversions", inversions_o, 0);
    end else begin
      want = pending_results.pop_front();
      if (inversions_o !== want.inv) report_mismatch("inversions", inversions_o, want.inv);
      if (error_o !== want.err) report_mismatch("error", error_o, want.err);
    end
    result_index++;
  endtask

  // receiver: checks accepted words and stalls on a changing pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run = $urandom_range(16, 200);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= stall_run[2];
    endcase
  end

  task automatic test_empty_rejects();
    send_word(CMD_DELETE, 32'h0, 11'd1);
    send_word(CMD_DELETE, 32'hffff_ffff, 11'd0);
    send_word(CMD_DELETE, 32'h0, 11'h7ff);
    send_word(CMD_DELETE, 32'h0, 11'd1024);
    send_word(CMD_UNUSED, 32'h8000_0000, 11'd5);
    send_word(CMD_CLEAR, 32'h1234_5678, 11'h3ff);
  endtask

  task automatic test_directed_sequence();
    send_word(CMD_LOAD, 32'h7fff_ffff, 11'h7ff);
    send_word(CMD_LOAD, 32'h8000_0000, 11'd0);
    send_word(CMD_LOAD, 32'h0000_0000, 11'd1);
    send_word(CMD_LOAD, 32'hffff_ffff, 11'h400);
    send_word(CMD_LOAD, 32'hffff_ffff, 11'd3);
    send_word(CMD_UNUSED, 32'h0, 11'd2);
    send_word(CMD_LOAD, 32'h0000_0005, 11'd0);
    send_word(CMD_LOAD, 32'h0000_0000, 11'd0);
    send_word(CMD_DELETE, 32'hdead_beef, 11'd3);
    send_word(CMD_DELETE, 32'h0, 11'd3);
    send_word(CMD_LOAD, 32'h0000_0009, 11'd0);
    send_word(CMD_DELETE, 32'h0, 11'd8);
    send_word(CMD_DELETE, 32'h7fff_ffff, 11'd7);
    send_word(CMD_DELETE, 32'h0, 11'd1);
    send_word(CMD_CLEAR, 32'h0, 11'd0);
    send_word(CMD_LOAD, 32'h0000_0001, 11'd0);
    send_word(CMD_LOAD, 32'h0000_0000, 11'd0);
    send_word(CMD_CLEAR, 32'hffff_ffff, 11'h7ff);
  endtask

  task automatic test_full_store();
    int k;
    for (k = 0; k < SEQ_DEPTH; k++)
      send_word(CMD_LOAD, IN_VAL_W'(64'sd2147483647 - longint'(k) * 64'sd4194000),
                POS_W'($urandom_range(0, 2047)));
    send_word(CMD_LOAD, 32'h8000_0000, 11'd0);
    send_word(CMD_DELETE, 32'h0, 11'd1);
    send_word(CMD_DELETE, 32'h0, 11'd1024);
    send_word(CMD_DELETE, 32'h0, 11'd512);
    send_word(CMD_DELETE, 32'h0, 11'd513);
    send_word(CMD_DELETE, 32'h0, 11'd1024);
    send_word(CMD_DELETE, 32'h0, 11'd1025);
    send_word(CMD_LOAD, 32'h0, 11'd0);
    send_word(CMD_CLEAR, 32'h0, 11'd0);
  endtask

  task automatic test_random_sequences();
    int                  sent;
    int                  n;
    int                  k;
    int                  j;
    int                  ops;
    int                  start;
    logic [IN_VAL_W-1:0] value;
    logic [POS_W-1:0]    pos;
    sent = 0;
    while (sent < 580) begin
      if ($urandom_range(0, 9) != 0) begin
        send_word(CMD_CLEAR, $urandom, POS_W'($urandom_range(0, 2047)));
        sent++;
      end
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 7))
          0, 1, 2: value = $urandom;
          3, 4:    value = IN_VAL_W'($signed($urandom_range(0, 8)) - 4);
          5:       value = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
          6:       value = ($urandom_range(0, 1) != 0) ? 32'h7fff_fff0 + $urandom_range(0, 15)
                                                      : 32'h8000_0000 + $urandom_range(0, 15);
          default: value = IN_VAL_W'($urandom_range(0, 1000));
        endcase
        send_word(CMD_LOAD, value, POS_W'($urandom_range(0, 2047)));
        sent++;
      end
      ops = $urandom_range(1, n + 3);
      for (k = 0; k < ops; k++) begin
        case ($urandom_range(0, 19))
          15: send_word(CMD_DELETE, $urandom, POS_W'($urandom_range(1, 2047)));
          16: send_word(CMD_DELETE, $urandom, 11'd0);
          17: send_word(CMD_LOAD, $urandom, POS_W'($urandom_range(0, 2047)));
          18: send_word(CMD_UNUSED, $urandom, POS_W'($urandom_range(0, 2047)));
          19: send_word(CMD_CLEAR, $urandom, POS_W'($urandom_range(0, 2047)));
          default: begin
            pos = POS_W'($urandom_range(1, 2047));
            if (seq_fill > 0) begin
              start = $urandom_range(0, seq_fill - 1);
              for (j = 0; j < seq_fill; j++)
                if (seq_live[(start + j) % seq_fill]) begin
                  pos = POS_W'((start + j) % seq_fill + 1);
                  break;
                end
            end
            send_word(CMD_DELETE, $urandom, pos);
          end
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_rejects();
    test_directed_sequence();
    test_full_store();
    test_random_sequences();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    $display("sent %0d loads, %0d deletes, %0d clears, %0d unknown commands; %0d rejected",
             n_loads, n_deletes, n_clears, n_other, n_rejected);
    $display("largest fill %0d, highest inversion count %0d, %0d words checked",
             peak_fill, peak_count, result_index);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timed out with %0d words outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
